// ----- rtl/mise_pkg.sv -----
package mise_pkg;

    localparam int unsigned DATA_BYTES  = 4096;
    localparam int unsigned STACK_BYTES = 512;
    localparam int unsigned DATA_AW     = $clog2(DATA_BYTES);
    localparam int unsigned STACK_AW    = $clog2(STACK_BYTES);

    localparam logic [31:0] PC_RESET        = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE_RESET = 32'h1001_0000;
    localparam logic [31:0] STACK_TOP_RESET = 32'h7fff_effc;
    localparam logic [31:0] SYSCALL_WORD    = 32'h0000_000c;

    localparam logic [4:0] SP_INDEX = 5'd29;
    localparam logic [4:0] RA_INDEX = 5'd31;
    localparam logic [4:0] V0_INDEX = 5'd2;
    localparam logic [4:0] A0_INDEX = 5'd4;

    localparam logic CFG_DATA_BASE = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BADADDR = 2'd2,
        ST_SYSCALL = 2'd3
    } status_t;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_SLTIU = 6'd11;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_XORI  = 6'd14;
    localparam logic [5:0] OP_LUI   = 6'd15;
    localparam logic [5:0] OP_SPEC2 = 6'd28;
    localparam logic [5:0] OP_LB    = 6'd32;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_LBU   = 6'd36;
    localparam logic [5:0] OP_SB    = 6'd40;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_SRA  = 6'd3;
    localparam logic [5:0] FN_SLLV = 6'd4;
    localparam logic [5:0] FN_SRLV = 6'd6;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_JALR = 6'd9;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_XOR  = 6'd38;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_SLT  = 6'd42;
    localparam logic [5:0] FN_SLTU = 6'd43;
    localparam logic [5:0] FN_MUL  = 6'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_EXEC  = 2'd1,
        PH_CLEAR = 2'd2
    } phase_t;

endpackage

// ----- rtl/mise_ram.sv -----
module mise_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/mips_integer_subset_executor.sv -----
// The register file is read when an instruction beat is accepted, and the execute
// state then computes the result, writes it back and registers the result beat.
// A load registers its byte memory read at the end of execute; its register write and
// result beat follow in the memory step. No new beat is accepted until the last one is
// through, a load through its memory step, and the result beat is taken or being taken.
// Reset (aresetn low, synchronous): pc, config registers and output valid are
// reset, then a pass over all 32 registers clears the register file (sp gets
// stack_top) while s_ready stays low. Byte memories are not cleared.
module mips_integer_subset_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic [1:0]  m_status,
    output logic        m_reg_write,
    output logic [4:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic [31:0] m_syscall_code,
    output logic [31:0] m_syscall_arg,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned DAW = mise_pkg::DATA_AW;
    localparam int unsigned SAW = mise_pkg::STACK_AW;

    mise_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  clr_reg, clr_next;
    logic [31:0] pc_reg, data_base_reg, stack_top_reg;
    logic [31:0] ins_reg;

    // Register file: two copies with a shared write port, one read port each.
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [31:0] rs_q, rt_q;
    logic [4:0]  rs_addr, rt_addr;

    logic ld_pend_reg;

    logic accept;
    assign accept = s_valid && s_ready;
    assign s_ready = (phase_reg == mise_pkg::PH_IDLE) && !ld_pend_reg &&
                     (!m_valid || m_ready);

    // On syscall the two ports read v0 and a0 instead of rs and rt.
    always_comb begin
        if (s_instruction == mise_pkg::SYSCALL_WORD) begin
            rs_addr = mise_pkg::V0_INDEX;
            rt_addr = mise_pkg::A0_INDEX;
        end else begin
            rs_addr = s_instruction[25:21];
            rt_addr = s_instruction[20:16];
        end
    end

    mise_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rs_addr), .rdata(rs_q)
    );
    mise_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rt_addr), .rdata(rt_q)
    );

    logic [31:0] a, b;
    assign a = (ins_reg[25:21] == 5'd0 && ins_reg != mise_pkg::SYSCALL_WORD) ? 32'd0 : rs_q;
    assign b = (ins_reg[20:16] == 5'd0 && ins_reg != mise_pkg::SYSCALL_WORD) ? 32'd0 : rt_q;

    // Byte memories: each region is split into four banks by the low two bits of
    // the byte index. The bytes of a word have consecutive indices within a region,
    // so they always land in different banks. The address is formed from rs_q in
    // the execute cycle; stores write at its end and loads get their data in the cycle after.
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [31:0] ea, simm;
    assign op   = ins_reg[31:26];
    assign fn   = ins_reg[5:0];
    assign simm = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign ea   = a + simm;

    // Per byte i of the access: mapping.
    logic [3:0]          in_stk, in_dat;
    logic [3:0][31:0]    ds, dd;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ds[i] = stack_top_reg - (ea + 32'(i));
            dd[i] = (ea + 32'(i)) - data_base_reg;
            in_stk[i] = ds[i] < 32'(mise_pkg::STACK_BYTES);
            in_dat[i] = !in_stk[i] && (dd[i] < 32'(mise_pkg::DATA_BYTES));
        end
    end

    logic [3:0]  st_we, dt_we;
    logic [3:0][SAW-3:0] st_addr;
    logic [3:0][DAW-3:0] dt_addr;
    logic [3:0][7:0] st_q, dt_q, st_wd, dt_wd, wbyte;

    for (genvar g = 0; g < 4; g++) begin : g_byte
        mise_ram #(.WIDTH(8), .DEPTH(mise_pkg::STACK_BYTES / 4)) u_stk (
            .aclk(aclk), .we(st_we[g]), .waddr(st_addr[g]), .wdata(st_wd[g]),
            .raddr(st_addr[g]), .rdata(st_q[g])
        );
        mise_ram #(.WIDTH(8), .DEPTH(mise_pkg::DATA_BYTES / 4)) u_dat (
            .aclk(aclk), .we(dt_we[g]), .waddr(dt_addr[g]), .wdata(dt_wd[g]),
            .raddr(dt_addr[g]), .rdata(dt_q[g])
        );
    end

    // Decode and execute.
    logic        is_load, is_store, is_word, addr_ok, wr;
    logic [31:0] val, nxt, pc4;
    logic [4:0]  dst;
    mise_pkg::status_t st;

    assign is_load  = (op == mise_pkg::OP_LB) || (op == mise_pkg::OP_LBU) ||
                      (op == mise_pkg::OP_LW);
    assign is_store = (op == mise_pkg::OP_SB) || (op == mise_pkg::OP_SW);
    assign is_word  = (op == mise_pkg::OP_LW) || (op == mise_pkg::OP_SW);
    assign addr_ok  = is_word ? ((ea[1:0] == 2'b00) && &(in_stk | in_dat))
                              : (in_stk[0] | in_dat[0]);
    assign pc4 = pc_reg + 32'd4;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            wbyte[i] = is_word ? b[31-8*i -: 8] : b[7:0];
        end
    end

    // Loads finish in the MEM cycle; everything else in EXEC.
    logic [3:0]      ld_stk_reg;
    logic [3:0][1:0] ld_sbank_reg, ld_dbank_reg;
    logic [5:0]      ld_op_reg;
    logic [4:0]      ld_dst_reg;

    always_comb begin
        wr  = 1'b0;
        dst = 5'd0;
        val = 32'd0;
        nxt = pc4;
        st  = mise_pkg::ST_OK;
        if (ins_reg == mise_pkg::SYSCALL_WORD) begin
            st = mise_pkg::ST_SYSCALL;
        end else begin
            case (op)
                mise_pkg::OP_RTYPE: begin
                    wr  = 1'b1;
                    dst = ins_reg[15:11];
                    case (fn)
                        mise_pkg::FN_ADD, mise_pkg::FN_ADDU: val = a + b;
                        mise_pkg::FN_SUB, mise_pkg::FN_SUBU: val = a - b;
                        mise_pkg::FN_AND: val = a & b;
                        mise_pkg::FN_OR:  val = a | b;
                        mise_pkg::FN_XOR: val = a ^ b;
                        mise_pkg::FN_NOR: val = ~(a | b);
                        mise_pkg::FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
                        mise_pkg::FN_SLTU: val = {31'd0, a < b};
                        mise_pkg::FN_SLL: val = b << ins_reg[10:6];
                        mise_pkg::FN_SRL: val = b >> ins_reg[10:6];
                        mise_pkg::FN_SRA: val = $unsigned($signed(b) >>> ins_reg[10:6]);
                        mise_pkg::FN_SLLV: val = b << a[4:0];
                        mise_pkg::FN_SRLV: val = b >> a[4:0];
                        mise_pkg::FN_JR: begin
                            wr  = 1'b0;
                            nxt = a;
                        end
                        mise_pkg::FN_JALR: begin
                            val = pc4;
                            nxt = a;
                        end
                        default: begin
                            wr = 1'b0;
                            st = mise_pkg::ST_INVALID;
                        end
                    endcase
                end
                mise_pkg::OP_SPEC2: begin
                    if (fn == mise_pkg::FN_MUL) begin
                        wr  = 1'b1;
                        dst = ins_reg[15:11];
                        val = a * b;
                    end else begin
                        st = mise_pkg::ST_INVALID;
                    end
                end
                mise_pkg::OP_J, mise_pkg::OP_JAL: begin
                    nxt = {pc4[31:28], ins_reg[25:0], 2'b00};
                    if (op == mise_pkg::OP_JAL) begin
                        wr  = 1'b1;
                        dst = mise_pkg::RA_INDEX;
                        val = pc4;
                    end
                end
                mise_pkg::OP_BEQ, mise_pkg::OP_BNE: begin
                    if ((op == mise_pkg::OP_BEQ) == (a == b)) begin
                        nxt = pc4 + {simm[29:0], 2'b00};
                    end
                end
                mise_pkg::OP_LB, mise_pkg::OP_LBU, mise_pkg::OP_LW,
                mise_pkg::OP_SB, mise_pkg::OP_SW: begin
                    if (!addr_ok) begin
                        st = mise_pkg::ST_BADADDR;
                    end
                end
                mise_pkg::OP_ADDI, mise_pkg::OP_ADDIU: begin
                    wr = 1'b1; dst = ins_reg[20:16]; val = a + simm;
                end
                mise_pkg::OP_SLTI: begin
                    wr = 1'b1; dst = ins_reg[20:16];
                    val = {31'd0, $signed(a) < $signed(simm)};
                end
                mise_pkg::OP_SLTIU: begin
                    wr = 1'b1; dst = ins_reg[20:16]; val = {31'd0, a < simm};
                end
                mise_pkg::OP_ANDI: begin
                    wr = 1'b1; dst = ins_reg[20:16]; val = a & {16'd0, ins_reg[15:0]};
                end
                mise_pkg::OP_ORI: begin
                    wr = 1'b1; dst = ins_reg[20:16]; val = a | {16'd0, ins_reg[15:0]};
                end
                mise_pkg::OP_XORI: begin
                    wr = 1'b1; dst = ins_reg[20:16]; val = a ^ {16'd0, ins_reg[15:0]};
                end
                mise_pkg::OP_LUI: begin
                    wr = 1'b1; dst = ins_reg[20:16]; val = {ins_reg[15:0], 16'd0};
                end
                default: st = mise_pkg::ST_INVALID;
            endcase
        end
        if (dst == 5'd0) begin
            wr = 1'b0;
        end
        if (!wr) begin
            dst = 5'd0;
            val = 32'd0;
        end
    end

    logic exec;
    assign exec = (phase_reg == mise_pkg::PH_EXEC);

    logic ld_go;
    assign ld_go = exec && is_load && addr_ok && (ins_reg[20:16] != 5'd0);

    // Each bank takes the one byte of the access whose index falls into it.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            st_we[j]   = 1'b0;
            dt_we[j]   = 1'b0;
            st_addr[j] = '0;
            dt_addr[j] = '0;
            st_wd[j]   = 8'd0;
            dt_wd[j]   = 8'd0;
            for (int i = 0; i < 4; i++) begin
                if ((is_word || i == 0) && in_stk[i] && ds[i][1:0] == 2'(j)) begin
                    st_we[j]   = exec && is_store && addr_ok;
                    st_addr[j] = ds[i][SAW-1:2];
                    st_wd[j]   = wbyte[i];
                end
                if ((is_word || i == 0) && in_dat[i] && dd[i][1:0] == 2'(j)) begin
                    dt_we[j]   = exec && is_store && addr_ok;
                    dt_addr[j] = dd[i][DAW-1:2];
                    dt_wd[j]   = wbyte[i];
                end
            end
        end
    end

    // Load data assembly in the cycle after EXEC.
    logic [3:0][7:0] lbytes;
    logic [31:0]     ld_val;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lbytes[i] = ld_stk_reg[i] ? st_q[ld_sbank_reg[i]] : dt_q[ld_dbank_reg[i]];
        end
        case (ld_op_reg)
            mise_pkg::OP_LW:  ld_val = {lbytes[0], lbytes[1], lbytes[2], lbytes[3]};
            mise_pkg::OP_LB:  ld_val = {{24{lbytes[0][7]}}, lbytes[0]};
            default:          ld_val = {24'd0, lbytes[0]};
        endcase
    end

    // Register file write port: clear pass, load, ALU result, or config sp, in that priority.
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = 5'd0;
        rf_wdata = 32'd0;
        if (phase_reg == mise_pkg::PH_CLEAR) begin
            rf_we    = 1'b1;
            rf_waddr = clr_reg;
            rf_wdata = (clr_reg == mise_pkg::SP_INDEX) ? stack_top_reg : 32'd0;
        end else if (ld_pend_reg) begin
            rf_we    = 1'b1;
            rf_waddr = ld_dst_reg;
            rf_wdata = ld_val;
        end else if (exec && wr && !is_load) begin
            rf_we    = 1'b1;
            rf_waddr = dst;
            rf_wdata = val;
        end else if (cfg_we && cfg_index == mise_pkg::CFG_STACK_TOP) begin
            rf_we    = 1'b1;
            rf_waddr = mise_pkg::SP_INDEX;
            rf_wdata = cfg_data;
        end
    end

    // A load finishes in the cycle after EXEC, so the next beat waits for it.
    always_comb begin
        phase_next = phase_reg;
        clr_next   = clr_reg;
        case (phase_reg)
            mise_pkg::PH_CLEAR: begin
                clr_next = clr_reg + 5'd1;
                if (clr_reg == 5'd31) begin
                    phase_next = mise_pkg::PH_IDLE;
                end
            end
            mise_pkg::PH_IDLE: begin
                if (accept) begin
                    phase_next = mise_pkg::PH_EXEC;
                end
            end
            mise_pkg::PH_EXEC: phase_next = mise_pkg::PH_IDLE;
            default: phase_next = mise_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= mise_pkg::PH_CLEAR;
            clr_reg       <= 5'd0;
            pc_reg        <= mise_pkg::PC_RESET;
            data_base_reg <= mise_pkg::DATA_BASE_RESET;
            stack_top_reg <= mise_pkg::STACK_TOP_RESET;
            m_valid       <= 1'b0;
            ld_pend_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            clr_reg     <= clr_next;
            ld_pend_reg <= ld_go;
            if (cfg_we) begin
                if (cfg_index == mise_pkg::CFG_DATA_BASE) begin
                    data_base_reg <= cfg_data;
                end else begin
                    stack_top_reg <= cfg_data;
                end
            end
            if (exec) begin
                pc_reg <= nxt;
                if (!ld_go) begin
                    m_valid <= 1'b1;
                end
            end else if (ld_pend_reg) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ins_reg <= s_instruction;
        end
        if (exec) begin
            ld_stk_reg     <= in_stk;
            for (int i = 0; i < 4; i++) begin
                ld_sbank_reg[i] <= ds[i][1:0];
                ld_dbank_reg[i] <= dd[i][1:0];
            end
            ld_op_reg      <= op;
            ld_dst_reg     <= ins_reg[20:16];
            m_next_pc      <= nxt;
            m_status       <= st;
            m_reg_write    <= wr;
            m_reg_index    <= dst;
            m_reg_value    <= val;
            m_syscall_code <= (st == mise_pkg::ST_SYSCALL) ? a : 32'd0;
            m_syscall_arg  <= (st == mise_pkg::ST_SYSCALL) ? b : 32'd0;
            if (ld_go) begin
                m_reg_write <= 1'b1;
                m_reg_index <= ins_reg[20:16];
            end
        end
        if (ld_pend_reg) begin
            m_reg_value <= ld_val;
        end
    end

endmodule

// ----- rtl/mise_checker.sv -----
module mise_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_reg_write,
    input logic [4:0]  m_reg_index,
    input logic [31:0] m_reg_value,
    input logic [31:0] m_syscall_code
);

    a_idx0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_write |-> m_reg_index == 5'd0 && m_reg_value == 32'd0)
        else $error("index or value without a register write");

    a_nozero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_write |-> m_reg_index != 5'd0)
        else $error("write to register zero reported");

    a_sys: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != mise_pkg::ST_SYSCALL |-> m_syscall_code == 32'd0)
        else $error("syscall code outside a syscall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reg_value))
        else $error("result beat dropped or changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("channels active right after reset");

endmodule

bind mips_integer_subset_executor mise_checker u_mise_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_reg_write(m_reg_write), .m_reg_index(m_reg_index),
    .m_reg_value(m_reg_value), .m_syscall_code(m_syscall_code)
);
